FILE: hw/rtl/hnit_pkg.sv
// hnit_pkg: shared types and codes for the hashed name interning table
// depends on nothing; imported by hnit_ram users and the top level
`default_nettype none

package hnit_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] name_hash;
    logic [63:0] name_word;
    logic [5:0]  entry_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [63:0] entry_hash;
    logic [63:0] entry_name;
    logic [6:0]  entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_ORD,
    S_BS_HASH,
    S_BS_CMP,
    S_SC_ORD,
    S_SC_ENT,
    S_SC_CMP,
    S_MISS,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_RD_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hashed_name_interning_table_unit.sv
// hashed_name_interning_table_unit: name interning table, sequencer around three rams
// add/find: a binary search of the order ram (up to ceil(log2(count+1)) steps), then a scan
//   of the entries with the key hash, ending on a match, on another hash or at the table end
// an add that inserts first shifts the order entries above the slot; read by index reads the entry
// bad read, zero hash or reserved code skip the search; one item at a time, out_stall holds it
// reset (synchronous, rst_n low) clears the entry count and the sequencer; rams not cleared
`default_nettype none

module hashed_name_interning_table_unit
  import hnit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int NAME_BITS     = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  state_t state_r, state_nxt;

  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        lb_r, lb_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        e_r, e_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [63:0]          key_hash_r, key_hash_nxt;
  logic [NAME_BITS-1:0] key_name_r, key_name_nxt;
  logic [2:0]           res_status_r, res_status_nxt;
  logic [5:0]           res_index_r, res_index_nxt;
  logic [63:0]          res_hash_r, res_hash_nxt;
  logic [63:0]          res_name_r, res_name_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // ram ports
  logic                 ord_we;
  logic [AW-1:0]        ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                 ent_we;
  logic [AW-1:0]        ent_waddr, ent_raddr;
  logic [63:0]          hash_rdata;
  logic [NAME_BITS-1:0] name_rdata;

  logic          accept;
  logic          out_free;
  logic          lo_lt_hi;
  logic          pos_lt_fill;
  logic          k_gt_lb;
  logic          table_full;
  logic          sel_ok;
  logic [CW-1:0] mid;
  logic [CW-1:0] k_dec;

  assign accept      = in_valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign lo_lt_hi    = lo_r < hi_r;
  assign pos_lt_fill = pos_r < fill_r;
  assign k_gt_lb     = k_r > lb_r;
  assign table_full  = fill_r >= CW'(TABLE_ENTRIES);
  assign sel_ok      = CMPW'(in_data.entry_select) < CMPW'(fill_r);
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign k_dec       = k_r - 1'b1;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hnit_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  hnit_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_hash_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (key_hash_r),
    .raddr (ent_raddr),
    .rdata (hash_rdata)
  );

  hnit_ram #(.WIDTH(NAME_BITS), .DEPTH(TABLE_ENTRIES)) u_name_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (key_name_r),
    .raddr (ent_raddr),
    .rdata (name_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_ADD || in_data.operation == OP_FIND) begin
            state_nxt = (in_data.name_hash == 64'd0) ? S_DONE : S_BS_ORD;
          end else if (in_data.operation == OP_READ && sel_ok) begin
            state_nxt = S_RD_WAIT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_BS_ORD:  state_nxt = lo_lt_hi ? S_BS_HASH : S_SC_ORD;
      S_BS_HASH: state_nxt = S_BS_CMP;
      S_BS_CMP:  state_nxt = S_BS_ORD;
      S_SC_ORD:  state_nxt = pos_lt_fill ? S_SC_ENT : S_MISS;
      S_SC_ENT:  state_nxt = S_SC_CMP;
      S_SC_CMP: begin
        if (hash_rdata != key_hash_r) begin
          state_nxt = S_MISS;
        end else if (name_rdata == key_name_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SC_ORD;
        end
      end
      S_MISS: begin
        if (op_r == OP_ADD && !table_full) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD:   state_nxt = k_gt_lb ? S_SH_WR : S_INS;
      S_SH_WR:   state_nxt = S_SH_RD;
      S_INS:     state_nxt = S_DONE;
      S_RD_WAIT: state_nxt = S_DONE;
      S_DONE:    state_nxt = out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    fill_nxt       = fill_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pos_nxt        = pos_r;
    lb_nxt         = lb_r;
    k_nxt          = k_r;
    e_nxt          = e_r;
    op_nxt         = op_r;
    key_hash_nxt   = key_hash_r;
    key_name_nxt   = key_name_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_hash_nxt   = res_hash_r;
    res_name_nxt   = res_name_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ord_we         = 1'b0;
    ord_waddr      = k_r[AW-1:0];
    ord_wdata      = ord_rdata;
    ord_raddr      = mid[AW-1:0];
    ent_we         = 1'b0;
    ent_waddr      = fill_r[AW-1:0];
    ent_raddr      = ord_rdata;
    case (state_r)
      S_IDLE: begin
        ent_raddr = AW'(in_data.entry_select);
        if (accept) begin
          op_nxt         = in_data.operation;
          key_hash_nxt   = in_data.name_hash;
          key_name_nxt   = in_data.name_word[NAME_BITS-1:0];
          lo_nxt         = '0;
          hi_nxt         = fill_r;
          res_index_nxt  = 6'd0;
          res_hash_nxt   = 64'd0;
          res_name_nxt   = 64'd0;
          res_status_nxt = ST_NOT_FOUND;
          if (in_data.operation == OP_ADD || in_data.operation == OP_FIND) begin
            if (in_data.name_hash == 64'd0) begin
              res_status_nxt = ST_INVALID;
            end
          end else if (in_data.operation == OP_READ) begin
            if (sel_ok) begin
              res_status_nxt = ST_FOUND;
              res_index_nxt  = in_data.entry_select;
            end else begin
              res_status_nxt = ST_RANGE;
            end
          end
        end
      end
      S_BS_ORD: begin
        // binary search for the lower bound of the key hash
        ord_raddr = mid[AW-1:0];
        if (!lo_lt_hi) begin
          pos_nxt = lo_r;
          lb_nxt  = lo_r;
        end
      end
      S_BS_HASH: begin
        ent_raddr = ord_rdata;
      end
      S_BS_CMP: begin
        if (hash_rdata < key_hash_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
      end
      S_SC_ORD: begin
        ord_raddr = pos_r[AW-1:0];
      end
      S_SC_ENT: begin
        ent_raddr = ord_rdata;
        e_nxt     = ord_rdata;
      end
      S_SC_CMP: begin
        if (hash_rdata == key_hash_r) begin
          if (name_rdata == key_name_r) begin
            res_status_nxt = (op_r == OP_ADD) ? ST_PRESENT : ST_FOUND;
            res_index_nxt  = 6'(e_r);
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_MISS: begin
        if (op_r == OP_ADD) begin
          if (table_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            k_nxt = fill_r;
          end
        end else begin
          res_status_nxt = ST_NOT_FOUND;
        end
      end
      S_SH_RD: begin
        // open a slot at the lower bound, moving one order entry up per pass
        ord_raddr = k_dec[AW-1:0];
      end
      S_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = k_r[AW-1:0];
        ord_wdata = ord_rdata;
        k_nxt     = k_dec;
      end
      S_INS: begin
        ord_we         = 1'b1;
        ord_waddr      = lb_r[AW-1:0];
        ord_wdata      = fill_r[AW-1:0];
        ent_we         = 1'b1;
        ent_waddr      = fill_r[AW-1:0];
        fill_nxt       = fill_r + 1'b1;
        res_status_nxt = ST_ADDED;
        res_index_nxt  = 6'(fill_r);
      end
      S_RD_WAIT: begin
        res_hash_nxt = hash_rdata;
        res_name_nxt = 64'(name_rdata);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.entry_index = res_index_r;
          out_data_nxt.entry_hash  = res_hash_r;
          out_data_nxt.entry_name  = res_name_r;
          out_data_nxt.entry_count = 7'(fill_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    pos_r        <= pos_nxt;
    lb_r         <= lb_nxt;
    k_r          <= k_nxt;
    e_r          <= e_nxt;
    op_r         <= op_nxt;
    key_hash_r   <= key_hash_nxt;
    key_name_r   <= key_name_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_hash_r   <= res_hash_nxt;
    res_name_r   <= res_name_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hnit_ram.sv
// hnit_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module hnit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
